@@ hdl/fan_curve_pwm_interpolator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Fan curve PWM interpolator assertion macros
// Shared property forms for the checkers of the fan curve PWM interpolator.
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_PWM_INTERPOLATOR_CORE_MACROS_SVH
`define FAN_CURVE_PWM_INTERPOLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCPI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcpi: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcpi: next-cycle check failed");

`endif

@@ hdl/fcpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Fan curve PWM interpolator package
// Shared constants, register codes, structures and the duty scaling function.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpi_pkg;

	localparam int POINTS      = 8;
	localparam int SEGMENTS    = POINTS - 1;
	localparam int DIV_STEPS   = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_TYPE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LOAD_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_TEMPS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_LOADS        = 3'd4;

	localparam logic [1:0] CH_UNKNOWN = 2'd0;
	localparam logic [1:0] CH_FAN     = 2'd1;
	localparam logic [1:0] CH_PUMP    = 2'd2;

	localparam logic signed [8:0] THR_OFF = -9'sd1;
	localparam logic [7:0] DUTY_MAX  = 8'd255;
	localparam logic [7:0] DUTY_MIN  = 8'd0;
	localparam logic [15:0] SCALE_255 = 16'd255;
	localparam logic [17:0] RECIP_100 = 18'd167773;

	typedef struct packed {
		logic [1:0]        channel_type;
		logic signed [8:0] max_load_threshold;
		logic [3:0]        point_count;
		logic [63:0]       point_temps;
		logic [63:0]       point_loads;
	} cfg_t;

	typedef struct packed {
		logic        direct;
		logic [7:0]  duty;
		logic [7:0]  base;
		logic [7:0]  mag;
		logic [11:0] span;
		logic [7:0]  dt;
	} cmd_t;

	// Duty is floor(255 * load / 100), saturated at full scale.
	function automatic logic [7:0] load_to_duty(input logic [7:0] load);
		logic [15:0] scaled;
		logic [33:0] prod;
		logic [9:0]  quo;
		scaled = 16'(load) * SCALE_255;
		prod   = 34'(scaled) * 34'(RECIP_100);
		quo    = prod[33:24];
		return (quo > 10'(DUTY_MAX)) ? DUTY_MAX : quo[7:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/fcpi_front.sv @@
// ----------------------------------------------------------------------------
// Fan curve front end
// Accepts sensor words, forms the temperature difference and classifies it
// against the curve into either a fixed duty or an interpolation command.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpi_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fcpi_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [11:0]  hot_temp,
	input  wire logic signed [11:0]  room_temp,
	input  wire logic                sensor_valid,
	input  wire logic [7:0]          chiller_load,
	output logic                     push_valid,
	input  wire logic                push_full,
	output fcpi_pkg::cmd_t           push_cmd
);

	logic                   adv;
	logic                   v_s1;
	logic signed [12:0]     delta_s1;
	logic                   sens_s1;
	logic [7:0]             load_s1;
	logic                   v_s2;
	fcpi_pkg::cmd_t         cmd_s2;

	logic [7:0]             tb   [fcpi_pkg::POINTS];
	logic signed [12:0]     t16  [fcpi_pkg::POINTS];
	logic [7:0]             ld   [fcpi_pkg::POINTS];
	logic                   hit  [fcpi_pkg::SEGMENTS];
	fcpi_pkg::cmd_t         lane [fcpi_pkg::SEGMENTS];
	logic signed [12:0]     dd;
	logic [7:0]             dt;
	logic [11:0]            den;
	logic [3:0]             cnt;
	logic [2:0]             last;
	logic                   fan;
	logic                   known;
	logic                   thr_hit;
	logic                   any_hit;
	fcpi_pkg::cmd_t         seg_cmd;
	fcpi_pkg::cmd_t         cmd_d;

	assign adv        = !v_s2 || !push_full;
	assign in_stall   = !adv;
	assign push_valid = v_s2;
	assign push_cmd   = cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			delta_s1 <= {hot_temp[11], hot_temp} - {room_temp[11], room_temp};
			sens_s1  <= sensor_valid;
			load_s1  <= chiller_load;
			cmd_s2   <= cmd_d;
		end
	end

	always_comb begin
		for (int i = 0; i < fcpi_pkg::POINTS; i++) begin
			tb[i]  = cfg.point_temps[8*i +: 8];
			t16[i] = {tb[i][7], tb[i], 4'b0000};
			ld[i]  = cfg.point_loads[8*i +: 8];
		end
	end

	assign cnt  = (cfg.point_count > 4'(fcpi_pkg::POINTS)) ? 4'(fcpi_pkg::POINTS)
	                                                         : cfg.point_count;
	assign last = 3'(cnt - 4'd1);

	always_comb begin
		for (int i = 0; i < fcpi_pkg::SEGMENTS; i++) begin
			dd  = delta_s1 - t16[i];
			dt  = tb[i+1] - tb[i];
			den = {dt, 4'b0000};
			hit[i] = (4'(i + 1) < cnt) && (delta_s1 >= t16[i]) && (delta_s1 <= t16[i+1]);
			lane[i].direct = 1'b0;
			lane[i].duty   = fcpi_pkg::DUTY_MIN;
			if (tb[i] == tb[i+1]) begin
				lane[i].base = ld[i];
				lane[i].mag  = 8'd0;
				lane[i].span = 12'd0;
				lane[i].dt   = 8'd1;
			end else if (ld[i+1] >= ld[i]) begin
				lane[i].base = ld[i];
				lane[i].mag  = ld[i+1] - ld[i];
				lane[i].span = dd[11:0];
				lane[i].dt   = dt;
			end else begin
				lane[i].base = ld[i+1];
				lane[i].mag  = ld[i] - ld[i+1];
				lane[i].span = den - dd[11:0];
				lane[i].dt   = dt;
			end
		end
	end

	always_comb begin
		any_hit = 1'b0;
		seg_cmd = lane[0];
		for (int i = fcpi_pkg::SEGMENTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				any_hit = 1'b1;
				seg_cmd = lane[i];
			end
		end
	end

	always_comb begin
		unique case (cfg.channel_type)
			fcpi_pkg::CH_FAN:  known = 1'b1;
			fcpi_pkg::CH_PUMP: known = 1'b1;
			default:           known = 1'b0;
		endcase
	end

	assign fan     = (cfg.channel_type == fcpi_pkg::CH_FAN);
	assign thr_hit = (cfg.max_load_threshold != fcpi_pkg::THR_OFF) &&
	                 ($signed({1'b0, load_s1}) > cfg.max_load_threshold);

	always_comb begin
		cmd_d.direct = 1'b0;
		cmd_d.duty   = fcpi_pkg::DUTY_MAX;
		cmd_d.base   = ld[last];
		cmd_d.mag    = 8'd0;
		cmd_d.span   = 12'd0;
		cmd_d.dt     = 8'd1;
		if (thr_hit || !known || !sens_s1) begin
			cmd_d.direct = 1'b1;
		end else if (cnt == 4'd0) begin
			cmd_d.direct = 1'b1;
			cmd_d.duty   = fan ? fcpi_pkg::DUTY_MIN : fcpi_pkg::DUTY_MAX;
		end else if (delta_s1 < t16[0]) begin
			cmd_d.direct = fan;
			cmd_d.duty   = fcpi_pkg::DUTY_MIN;
			cmd_d.base   = ld[0];
		end else if (delta_s1 > t16[last]) begin
			cmd_d.base = ld[last];
		end else if (any_hit) begin
			cmd_d = seg_cmd;
		end
	end

endmodule

`default_nettype wire

@@ hdl/fcpi_queue.sv @@
// ----------------------------------------------------------------------------
// Fan curve command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpi_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_full,
	input  wire fcpi_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output fcpi_pkg::cmd_t      pop_cmd
);

	fcpi_pkg::cmd_t                mem_q [fcpi_pkg::QUEUE_DEPTH];
	logic [fcpi_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [fcpi_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [fcpi_pkg::QPTR_W:0]     count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_full = (count_q == (fcpi_pkg::QPTR_W + 1)'(fcpi_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop_valid && pop_ready;
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ hdl/fcpi_back.sv @@
// ----------------------------------------------------------------------------
// Fan curve back end
// Multiplies the load step by the position in the segment, divides by the
// segment width in a pipelined restoring divider and scales the load to duty.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpi_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire fcpi_pkg::cmd_t pop_cmd,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          duty
);

	localparam int NST = fcpi_pkg::DIV_STEPS + 1;

	logic        en;
	logic [19:0] prod;
	logic        vld_s    [NST];
	logic        direct_s [NST];
	logic [7:0]  dduty_s  [NST];
	logic [7:0]  base_s   [NST];
	logic [7:0]  dt_s     [NST];
	logic [7:0]  rem_s    [NST];
	logic [7:0]  qsh_s    [NST];
	logic        ld_valid_s10;
	logic        ld_direct_s10;
	logic [7:0]  ld_duty_s10;
	logic [7:0]  ld_s10;
	logic        out_valid_q;
	logic [7:0]  duty_q;

	function automatic logic [15:0] div_step(input logic [7:0] rem, input logic [7:0] qsh,
	                                         input logic [7:0] dvs);
		logic [8:0] trial;
		logic [7:0] nrem;
		logic       qbit;
		trial = {rem, qsh[7]};
		if (trial >= {1'b0, dvs}) begin
			nrem = 8'(trial - {1'b0, dvs});
			qbit = 1'b1;
		end else begin
			nrem = trial[7:0];
			qbit = 1'b0;
		end
		return {nrem, qsh[6:0], qbit};
	endfunction

	assign en        = !out_valid_q || !out_stall;
	assign pop_ready = en;
	assign out_valid = out_valid_q;
	assign duty      = duty_q;
	assign prod      = 20'(pop_cmd.mag) * 20'(pop_cmd.span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld_s[k] <= 1'b0;
			end
			ld_valid_s10 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop_valid;
			for (int k = 1; k < NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			ld_valid_s10 <= vld_s[NST-1];
			out_valid_q  <= ld_valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			direct_s[0] <= pop_cmd.direct;
			dduty_s[0]  <= pop_cmd.duty;
			base_s[0]   <= pop_cmd.base;
			dt_s[0]     <= pop_cmd.dt;
			rem_s[0]    <= prod[19:12];
			qsh_s[0]    <= prod[11:4];
			for (int k = 1; k < NST; k++) begin
				direct_s[k]            <= direct_s[k-1];
				dduty_s[k]             <= dduty_s[k-1];
				base_s[k]              <= base_s[k-1];
				dt_s[k]                <= dt_s[k-1];
				{rem_s[k], qsh_s[k]}   <= div_step(rem_s[k-1], qsh_s[k-1], dt_s[k-1]);
			end
			ld_direct_s10 <= direct_s[NST-1];
			ld_duty_s10   <= dduty_s[NST-1];
			ld_s10        <= base_s[NST-1] + qsh_s[NST-1];
			duty_q        <= ld_direct_s10 ? ld_duty_s10 : fcpi_pkg::load_to_duty(ld_s10);
		end
	end

endmodule

`default_nettype wire

@@ hdl/fan_curve_pwm_interpolator_core.sv @@
// Throughput: one word per cycle while the output is not stalled, set by the
// fully pipelined eight-step divider.
// A four-entry queue lets the front end keep accepting while the output stalls.
// Reset clears the configuration to its defaults and empties every stage.
// ----------------------------------------------------------------------------
// Fan curve PWM interpolator core
// Configuration registers, front end, command queue and divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_curve_pwm_interpolator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fcpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fcpi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [11:0]              hot_temp,
	input  wire logic signed [11:0]              room_temp,
	input  wire logic                            sensor_valid,
	input  wire logic [7:0]                      chiller_load,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           duty
);

	logic [1:0]        channel_type_q;
	logic signed [8:0] max_load_threshold_q;
	logic [3:0]        point_count_q;
	logic [63:0]       point_temps_q;
	logic [63:0]       point_loads_q;
	fcpi_pkg::cfg_t    cfg;
	logic              push_valid;
	logic              push_full;
	fcpi_pkg::cmd_t    push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	fcpi_pkg::cmd_t    pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_type_q       <= fcpi_pkg::CH_UNKNOWN;
			max_load_threshold_q <= fcpi_pkg::THR_OFF;
			point_count_q        <= 4'd0;
			point_temps_q        <= 64'd0;
			point_loads_q        <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fcpi_pkg::REG_CHANNEL_TYPE:       channel_type_q       <= cfg_data[1:0];
				fcpi_pkg::REG_MAX_LOAD_THRESHOLD: max_load_threshold_q <= cfg_data[8:0];
				fcpi_pkg::REG_POINT_COUNT:        point_count_q        <= cfg_data[3:0];
				fcpi_pkg::REG_POINT_TEMPS:        point_temps_q        <= cfg_data;
				fcpi_pkg::REG_POINT_LOADS:        point_loads_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.channel_type       = channel_type_q;
		cfg.max_load_threshold = max_load_threshold_q;
		cfg.point_count        = point_count_q;
		cfg.point_temps        = point_temps_q;
		cfg.point_loads        = point_loads_q;
	end

	fcpi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.hot_temp     (hot_temp),
		.room_temp    (room_temp),
		.sensor_valid (sensor_valid),
		.chiller_load (chiller_load),
		.push_valid   (push_valid),
		.push_full    (push_full),
		.push_cmd     (push_cmd)
	);

	fcpi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	fcpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty      (duty)
	);

endmodule

`default_nettype wire

@@ hdl/fcpi_checker.sv @@
// ----------------------------------------------------------------------------
// Fan curve PWM interpolator checker
// Port-level properties of the core, attached to every instance by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_curve_pwm_interpolator_core_macros.svh"

module fcpi_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_ready,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] duty
);

	// A word waiting at the output holds until it is taken.
	`FCPI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(duty))

	// Leaving reset, the pipeline is empty and the input side is open.
	`FCPI_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid && !in_stall)

	// Configuration writes are never refused.
	`FCPI_ASSERT_SAME(a_cfg_open, clk, arst_n, 1'b1, cfg_ready)

endmodule

bind fan_curve_pwm_interpolator_core fcpi_checker u_fcpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.duty      (duty)
);

`default_nettype wire
